// ----- rtl/lgge_pkg.sv -----
package lgge_pkg;

    // default grid size
    localparam int DEF_GRID_COLUMNS = 128;
    localparam int DEF_GRID_ROWS    = 32;

    // fixed payload widths
    localparam int FUNC_W        = 2;
    localparam int COLUMN_W      = 7;
    localparam int COLUMN_BITS_W = 32;
    localparam int BYTE_INDEX_W  = 9;
    localparam int READ_BYTE_W   = 8;
    localparam int POP_W         = 13;

    // byte index split: reciprocal multiply, exact for 9-bit indexes and up to 128 bytes a row
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int IDX_PROD_W  = BYTE_INDEX_W + RECIP_W;

    // one column read per packed cell
    localparam int FETCH_CNT_W = 4;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GEN,
        ST_RD_DIV,
        ST_RD_SPLIT,
        ST_RD_FETCH,
        ST_RESP
    } t_state;

endpackage

// ----- rtl/life_grid_generation_engine_top.sv -----
// each function ends in the output register: a column write or unused code straight from idle,
//   a generation after its sweep, a display byte read after the index split and column fetch
// throughput: one item at a time; a generation sweeps one column a cycle through the
//   single read port of the grid memory, a byte read fetches eight columns one by one
// reset: synchronous, active low; afterwards a clearing pass writes every column dead
//   while the input stays stalled
module life_grid_generation_engine_top #(
    parameter int GRID_COLUMNS = lgge_pkg::DEF_GRID_COLUMNS,
    parameter int GRID_ROWS    = lgge_pkg::DEF_GRID_ROWS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lgge_pkg::FUNC_W-1:0]        i_func,
    input  logic [lgge_pkg::COLUMN_W-1:0]      i_column,
    input  logic [lgge_pkg::COLUMN_BITS_W-1:0] i_column_bits,
    input  logic [lgge_pkg::BYTE_INDEX_W-1:0]  i_byte_index,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lgge_pkg::READ_BYTE_W-1:0]   o_read_byte,
    output logic [lgge_pkg::POP_W-1:0]         o_population,
    output logic                               o_stable
);

    localparam int CW        = $clog2(GRID_COLUMNS);
    localparam int CNT_W     = CW + 1;
    localparam int RW        = $clog2(GRID_ROWS);
    localparam int BPR       = (GRID_COLUMNS + 7) / 8;
    localparam int RD_TOTAL  = BPR * GRID_ROWS;
    localparam int RD_RECIP  = ((1 << lgge_pkg::RECIP_SHIFT) + BPR - 1) / BPR;
    localparam int POP_LANES = (GRID_ROWS + 7) / 8;
    localparam int POP_PAD_W = POP_LANES * 8;
    localparam int POP_CNT_W = $clog2(GRID_ROWS + 1);

    localparam logic [CNT_W-1:0] COLS_N   = CNT_W'(GRID_COLUMNS);
    localparam logic [CW-1:0]    LAST_COL = CW'(GRID_COLUMNS - 1);

    // fsm and control
    lgge_pkg::t_state r_state, n_state;
    logic                   in_acc;
    logic                   out_load;
    logic                   iss_go;
    logic                   fet_go;
    logic                   gen_we;
    logic                   mem_we;
    logic [CW-1:0]          mem_waddr;
    logic [GRID_ROWS-1:0]   mem_wdata;
    logic [CW-1:0]          mem_raddr;

    // grid memory
    logic [GRID_ROWS-1:0]   r_grid_mem [GRID_COLUMNS];
    logic [GRID_ROWS-1:0]   r_rd_data;

    // clearing pass
    logic [CW-1:0]          r_clr_addr;

    // generation sweep
    logic [CNT_W-1:0]       r_iss_idx;
    logic                   r_a_vld;
    logic                   r_a_pad;
    logic [CNT_W-1:0]       r_a_idx;
    logic                   r_b_vld;
    logic [CNT_W-1:0]       r_b_idx;
    logic                   r_c_vld;
    logic                   r_c_last;
    logic [GRID_ROWS-1:0]   r_c_col;
    logic [GRID_ROWS-1:0]   r_win_l;
    logic [GRID_ROWS-1:0]   r_win_c;
    logic [GRID_ROWS-1:0]   r_win_r;
    logic [GRID_ROWS-1:0]   gen_col;
    logic [CNT_W-1:0]       gen_idx;
    logic [POP_CNT_W-1:0]   col_cnt;
    logic [lgge_pkg::POP_W:0]   pop_sum;
    logic [lgge_pkg::POP_W-1:0] pop_sat;
    logic [lgge_pkg::POP_W-1:0] r_pop_acc;
    logic [lgge_pkg::POP_W-1:0] r_last_pop;
    logic                       r_last_stable;

    // display byte read
    logic [lgge_pkg::BYTE_INDEX_W-1:0]  r_idx;
    logic [lgge_pkg::BYTE_INDEX_W-1:0]  r_q;
    logic [lgge_pkg::IDX_PROD_W-1:0]    idx_prod;
    logic [lgge_pkg::BYTE_INDEX_W-1:0]  rd_bcol;
    logic                               r_rd_oob;
    logic [RW-1:0]                      r_row;
    logic [CNT_W-1:0]                   r_rd_col;
    logic [lgge_pkg::FETCH_CNT_W-1:0]   r_fet_cnt;
    logic                               r_f_vld;
    logic                               r_f_inr;
    logic                               r_f_last;
    logic [lgge_pkg::READ_BYTE_W-1:0]   r_rd_byte;

    // output register
    logic                               r_out_vld;
    logic [lgge_pkg::READ_BYTE_W-1:0]   r_out_byte;
    logic [lgge_pkg::POP_W-1:0]         r_out_pop;
    logic                               r_out_stable;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lgge_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_COL) n_state = lgge_pkg::ST_IDLE;
            end
            lgge_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_func)
                        lgge_pkg::FUNC_STEP: n_state = lgge_pkg::ST_GEN;
                        lgge_pkg::FUNC_READ: n_state = lgge_pkg::ST_RD_DIV;
                        default:             n_state = lgge_pkg::ST_RESP;
                    endcase
                end
            end
            lgge_pkg::ST_GEN: begin
                if (r_c_vld && r_c_last) n_state = lgge_pkg::ST_RESP;
            end
            lgge_pkg::ST_RD_DIV:   n_state = lgge_pkg::ST_RD_SPLIT;
            lgge_pkg::ST_RD_SPLIT: n_state = lgge_pkg::ST_RD_FETCH;
            lgge_pkg::ST_RD_FETCH: begin
                if (r_f_vld && r_f_last) n_state = lgge_pkg::ST_RESP;
            end
            lgge_pkg::ST_RESP: begin
                if (out_load) n_state = lgge_pkg::ST_IDLE;
            end
            default: n_state = lgge_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs and memory port selection
    always_comb begin
        o_in_stall = (r_state != lgge_pkg::ST_IDLE);
        in_acc     = i_in_valid && (r_state == lgge_pkg::ST_IDLE);
        out_load   = 1'b0;
        iss_go     = 1'b0;
        fet_go     = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_clr_addr;
        mem_wdata  = '0;
        mem_raddr  = r_iss_idx[CW-1:0];
        unique case (r_state)
            lgge_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            lgge_pkg::ST_IDLE: begin
                if (in_acc && (i_func == lgge_pkg::FUNC_WRITE)
                        && (32'(i_column) < 32'(GRID_COLUMNS))) begin
                    mem_we    = 1'b1;
                    mem_waddr = CW'(i_column);
                    mem_wdata = GRID_ROWS'(i_column_bits);
                end
            end
            lgge_pkg::ST_GEN: begin
                iss_go    = (r_iss_idx <= COLS_N);
                mem_we    = gen_we;
                mem_waddr = gen_idx[CW-1:0];
                mem_wdata = gen_col;
            end
            lgge_pkg::ST_RD_DIV, lgge_pkg::ST_RD_SPLIT: begin
            end
            lgge_pkg::ST_RD_FETCH: begin
                fet_go    = (r_fet_cnt < lgge_pkg::FETCH_CNT_W'(lgge_pkg::READ_BYTE_W));
                mem_raddr = r_rd_col[CW-1:0];
            end
            lgge_pkg::ST_RESP: begin
                out_load = !r_out_vld || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    // grid memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_grid_mem[mem_waddr] <= mem_wdata;
        r_rd_data <= r_grid_mem[mem_raddr];
    end

    // next column from the three-column window, one lane per row
    always_comb begin
        logic [GRID_ROWS-1:0] l_dn, l_up, c_dn, c_up, r_dn, r_up;
        logic [3:0]           nb;
        l_dn = r_win_l << 1;
        l_up = r_win_l >> 1;
        c_dn = r_win_c << 1;
        c_up = r_win_c >> 1;
        r_dn = r_win_r << 1;
        r_up = r_win_r >> 1;
        for (int i = 0; i < GRID_ROWS; i++) begin
            nb = 4'(l_dn[i]) + 4'(r_win_l[i]) + 4'(l_up[i]) + 4'(c_dn[i])
               + 4'(c_up[i]) + 4'(r_dn[i]) + 4'(r_win_r[i]) + 4'(r_up[i]);
            gen_col[i] = (nb == 4'd3) || (r_win_c[i] && (nb == 4'd2));
        end
    end

    assign gen_we  = r_b_vld && (r_b_idx != '0);
    assign gen_idx = r_b_idx - CNT_W'(1);

    // live cells of the finished column, byte lanes then lane sum
    always_comb begin
        logic [POP_PAD_W-1:0] pad;
        logic [3:0]           lane_cnt [POP_LANES];
        pad = POP_PAD_W'(r_c_col);
        for (int l = 0; l < POP_LANES; l++) begin
            lane_cnt[l] = '0;
            for (int b = 0; b < 8; b++) begin
                lane_cnt[l] = lane_cnt[l] + 4'(pad[l*8+b]);
            end
        end
        col_cnt = '0;
        for (int l = 0; l < POP_LANES; l++) begin
            col_cnt = col_cnt + POP_CNT_W'(lane_cnt[l]);
        end
    end

    // saturating population accumulate
    assign pop_sum = {1'b0, r_pop_acc} + (lgge_pkg::POP_W + 1)'(col_cnt);
    assign pop_sat = pop_sum[lgge_pkg::POP_W] ? '1 : pop_sum[lgge_pkg::POP_W-1:0];

    // byte index split into row and byte column
    assign idx_prod = lgge_pkg::IDX_PROD_W'(r_idx)
                    * lgge_pkg::IDX_PROD_W'(RD_RECIP);
    assign rd_bcol  = r_idx - lgge_pkg::BYTE_INDEX_W'(32'(r_q) * 32'(BPR));

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lgge_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_iss_idx     <= '0;
            r_a_vld       <= 1'b0;
            r_b_vld       <= 1'b0;
            r_c_vld       <= 1'b0;
            r_f_vld       <= 1'b0;
            r_fet_cnt     <= '0;
            r_out_vld     <= 1'b0;
            r_last_pop    <= '0;
            r_last_stable <= 1'b0;
        end else begin
            r_state <= n_state;

            // clearing pass
            if (r_state == lgge_pkg::ST_CLEAR) r_clr_addr <= r_clr_addr + CW'(1);

            // sweep issue and stage valids
            if (in_acc) begin
                r_iss_idx <= '0;
                r_fet_cnt <= '0;
            end else begin
                if (iss_go) r_iss_idx <= r_iss_idx + CNT_W'(1);
                if (fet_go) r_fet_cnt <= r_fet_cnt + lgge_pkg::FETCH_CNT_W'(1);
            end
            r_a_vld <= iss_go;
            r_b_vld <= r_a_vld;
            r_c_vld <= gen_we;
            r_f_vld <= fet_go;

            // generation totals
            if (r_c_vld && r_c_last) begin
                r_last_pop    <= pop_sat;
                r_last_stable <= (pop_sat == r_last_pop);
            end

            // output beat
            if (out_load) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // accepted beat
        if (in_acc) begin
            r_idx     <= i_byte_index;
            r_rd_byte <= '0;
            r_win_c   <= '0;
            r_win_r   <= '0;
            r_pop_acc <= '0;
        end

        // sweep stage a: read issued
        if (iss_go) begin
            r_a_idx <= r_iss_idx;
            r_a_pad <= (r_iss_idx == COLS_N);
        end

        // sweep stage b: window shift
        if (r_a_vld) begin
            r_win_l <= r_win_c;
            r_win_c <= r_win_r;
            r_win_r <= r_a_pad ? '0 : r_rd_data;
            r_b_idx <= r_a_idx;
        end

        // sweep stage c: new column registered for counting
        if (gen_we) begin
            r_c_col  <= gen_col;
            r_c_last <= (r_b_idx == COLS_N);
        end
        if (r_c_vld) r_pop_acc <= pop_sat;

        // byte read: split index, then fetch eight columns
        if (r_state == lgge_pkg::ST_RD_DIV) begin
            r_q      <= idx_prod[lgge_pkg::RECIP_SHIFT +: lgge_pkg::BYTE_INDEX_W];
            r_rd_oob <= (32'(r_idx) >= 32'(RD_TOTAL));
        end
        if (r_state == lgge_pkg::ST_RD_SPLIT) begin
            r_row    <= r_q[RW-1:0];
            r_rd_col <= CNT_W'(32'(rd_bcol) << 3);
        end
        if (fet_go) begin
            r_rd_col <= r_rd_col + CNT_W'(1);
            r_f_inr  <= (r_rd_col < COLS_N) && !r_rd_oob;
            r_f_last <= (r_fet_cnt == lgge_pkg::FETCH_CNT_W'(lgge_pkg::READ_BYTE_W - 1));
        end
        if (r_f_vld) begin
            r_rd_byte <= {r_rd_byte[lgge_pkg::READ_BYTE_W-2:0], r_f_inr && r_rd_data[r_row]};
        end

        // output payload
        if (out_load) begin
            r_out_byte   <= r_rd_byte;
            r_out_pop    <= r_last_pop;
            r_out_stable <= r_last_stable;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_read_byte  = r_out_byte;
    assign o_population = r_out_pop;
    assign o_stable     = r_out_stable;

`ifndef SYNTH
    // a column is written back only after its right neighbor was read
    a_gen_write_trails_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgge_pkg::ST_GEN && gen_we) |-> (r_b_idx < r_iss_idx))
        else $error("generation write overtakes column read");

    // sweep stages run only during a generation
    a_sweep_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld || r_b_vld || r_c_vld) |-> (r_state == lgge_pkg::ST_GEN))
        else $error("sweep stage active outside generation");

    // last counted column hands over to the response
    a_gen_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && r_c_last) |=> (r_state == lgge_pkg::ST_RESP))
        else $error("generation did not finish");

    // the response state always leaves a beat in the output register
    a_resp_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lgge_pkg::ST_RESP && out_load) |=> r_out_vld)
        else $error("response beat lost");
`endif

endmodule
